FILE: hdl/bdaq_pkg.sv
// Package for the button debounce action queue: payload structs, action,
// command and system state codes, register indexes and the hold-time compare.
// No dependencies.
package bdaq_pkg;

	// default queue depth for the top level parameter
	localparam int QUEUE_DEPTH_DEF = 8;

	localparam int NUM_BTN  = 9;
	localparam int NUM_PAIR = 3;
	localparam int TIME_W   = 63;
	localparam int REG_W    = 32;
	localparam int REG_IDX_W = 2;

	// debouncer slots
	localparam int BTN_VOICE = 0;
	localparam int BTN_PAIR  = 1;
	localparam int BTN_BOOT  = 2;
	localparam int BTN_EXPR  = 3;
	localparam int BTN_VUP   = 4;
	localparam int BTN_VDN   = 5;
	localparam int BTN_NEXT  = 6;
	localparam int BTN_PREV  = 7;
	localparam int BTN_TOUCH = 8;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DISCOVERY = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CONFIRM   = 2'd2;

	// register reset values
	localparam logic [REG_W-1:0] DEBOUNCE_RST  = 32'd30000;
	localparam logic [REG_W-1:0] DISCOVERY_RST = 32'd3000000;
	localparam logic [REG_W-1:0] CONFIRM_RST   = 32'd1500000;

	typedef enum logic [0:0] {
		CMD_TICK = 1'b0,
		CMD_POP  = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		ST_IDLE      = 2'd0,
		ST_RECORDING = 2'd1,
		ST_ARMED     = 2'd2,
		ST_OTHER     = 2'd3
	} sys_state_t;

	typedef enum logic [3:0] {
		ACT_NONE        = 4'd0,
		ACT_VOICE_START = 4'd1,
		ACT_VOICE_STOP  = 4'd2,
		ACT_DISCOVERY   = 4'd3,
		ACT_CONFIRM     = 4'd4,
		ACT_EXPRESSION  = 4'd5,
		ACT_TOUCH       = 4'd6,
		ACT_VOL_UP      = 4'd7,
		ACT_VOL_DOWN    = 4'd8,
		ACT_NEXT        = 4'd9,
		ACT_PREV        = 4'd10
	} action_t;

	typedef struct packed {
		command_t            command;
		logic                voice_level;
		logic                pair_level;
		logic                boot_level;
		logic                expression_level;
		logic                volume_up_level;
		logic                volume_down_level;
		logic                next_track_level;
		logic                prev_track_level;
		logic                touch_level;
		logic [TIME_W-1:0]   sample_time_us;
		sys_state_t          system_state;
	} in_item_t;

	typedef struct packed {
		action_t    action;
		logic [3:0] pending_count;
	} out_item_t;

	// true when now - t_ref >= thr, with now below t_ref counting as negative
	function automatic logic elapsed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] t_ref,
			logic [REG_W-1:0] thr);
		logic [TIME_W:0] limit;
		limit = {1'b0, t_ref} + {{(TIME_W + 1 - REG_W){1'b0}}, thr};
		return {1'b0, now} >= limit;
	endfunction

endpackage

FILE: hdl/button_debounce_action_queue.sv
// Top level of the button debounce action queue: input register, debounce and
// action policy, shift-down action queue and output register.
// Depends on bdaq_pkg.
//
// Usage: one input channel (in_valid / in_stall / in_data) carries items that
// are either a sample tick with nine raw button levels, a timestamp and the
// system state, or a pop command. Every item gives exactly one result on the
// output channel (out_valid / out_stall / out_data): a tick reports action
// none and the queue count after its pushes, a pop reports the oldest queued
// action (none when empty) and the count left.
// A result passes the input and output registers; one item is taken every
// cycle while in_stall is low. All debouncers, hold timers and up to six
// queue pushes of a tick are resolved in the single stage between the input
// register and the output register, each debouncer with one 64-bit add and
// compare. When the receiver stalls, the result holds in the output register;
// an empty input register takes one more item, after which in_stall rises.
// Reset clears all button state, the queue count and both pipeline stages,
// and loads the three timing registers with their defaults. The user writes
// registers through cfg_we / cfg_index / cfg_data only while no item is in
// flight; the block does not enforce it. An index beyond the list is ignored.
module button_debounce_action_queue #(
	parameter int QUEUE_DEPTH = bdaq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bdaq_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [bdaq_pkg::REG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  bdaq_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output bdaq_pkg::out_item_t               out_data
);
	import bdaq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = $clog2(QUEUE_DEPTH + 7);
	localparam int NPUSH = 6;

	// configuration registers
	logic [REG_W-1:0] debounce_q, discovery_q, confirm_q;

	// pipeline registers
	logic      s1_valid_q;
	in_item_t  s1_data_s1;
	logic      out_valid_q;
	out_item_t out_data_q;

	// button state
	logic [NUM_BTN-1:0]               raw_q, raw_d;
	logic [NUM_BTN-1:0]               stable_q, stable_d;
	logic [NUM_BTN-1:0][TIME_W-1:0]   change_time_q, change_time_d;
	logic [NUM_PAIR-1:0][TIME_W-1:0]  press_start_q, press_start_d;
	logic [NUM_PAIR-1:0]              hold_done_q, hold_done_d;
	logic [NUM_PAIR-1:0]              released_q, released_d;
	logic                             prev_armed_q, prev_armed_d;
	logic                             rel_req_q, rel_req_d;

	// action queue, head at entry 0
	action_t         fifo_q [QUEUE_DEPTH];
	action_t         fifo_d [QUEUE_DEPTH];
	logic [CW-1:0]   count_q, count_d;

	logic      advance, commit;
	out_item_t result;

	assign advance   = !out_valid_q || !out_stall;
	assign commit    = s1_valid_q && advance;
	assign in_stall  = s1_valid_q && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RST;
			discovery_q <= DISCOVERY_RST;
			confirm_q   <= CONFIRM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:  debounce_q  <= cfg_data;
				REG_DISCOVERY: discovery_q <= cfg_data;
				REG_CONFIRM:   confirm_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			s1_data_s1 <= in_data;
		end
	end

	// debounce, action policy and queue update
	always_comb begin
		logic [NUM_BTN-1:0]           lv;
		logic [NUM_BTN-1:0]           flip;
		logic [NUM_BTN-1:0]           pressed;
		logic [NUM_PAIR-1:0]          hold_t, rel_t, fire;
		logic [NUM_PAIR-1:0]          el_disc, el_conf, start_now;
		logic                         deb_ok, changed, raw_pair, stab_pair, armed, any_fire;
		logic [NPUSH-1:0]             push_v;
		action_t                      push_a [NPUSH];
		logic [PW-1:0]                pos [NPUSH];
		logic [PW-1:0]                total;
		logic [7:0]                   cnt_ext;
		logic [TIME_W-1:0]            now;
		sys_state_t                   st;

		now = s1_data_s1.sample_time_us;
		st  = s1_data_s1.system_state;
		lv[BTN_VOICE] = s1_data_s1.voice_level;
		lv[BTN_PAIR]  = s1_data_s1.pair_level;
		lv[BTN_BOOT]  = s1_data_s1.boot_level;
		lv[BTN_EXPR]  = s1_data_s1.expression_level;
		lv[BTN_VUP]   = s1_data_s1.volume_up_level;
		lv[BTN_VDN]   = s1_data_s1.volume_down_level;
		lv[BTN_NEXT]  = s1_data_s1.next_track_level;
		lv[BTN_PREV]  = s1_data_s1.prev_track_level;
		lv[BTN_TOUCH] = s1_data_s1.touch_level;

		// hold current state by default
		raw_d         = raw_q;
		stable_d      = stable_q;
		change_time_d = change_time_q;
		press_start_d = press_start_q;
		hold_done_d   = hold_done_q;
		released_d    = released_q;
		prev_armed_d  = prev_armed_q;
		rel_req_d     = rel_req_q;
		count_d       = count_q;
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			fifo_d[k] = fifo_q[k];
		end
		result.action        = ACT_NONE;
		result.pending_count = '0;

		// per-button debouncers; a fresh change passes only with zero debounce time
		for (int i = 0; i < NUM_BTN; i++) begin
			changed = lv[i] != raw_q[i];
			raw_d[i] = lv[i];
			if (changed) begin
				change_time_d[i] = now;
			end
			deb_ok = changed ? (debounce_q == '0) : elapsed(now, change_time_q[i], debounce_q);
			flip[i] = (stable_q[i] != lv[i]) && deb_ok;
			if (flip[i]) begin
				stable_d[i] = lv[i];
			end
			pressed[i] = flip[i] && lv[i];
		end

		// pairing button hold timers
		for (int j = 0; j < NUM_PAIR; j++) begin
			start_now[j] = flip[j + 1] && lv[j + 1];
			hold_t[j] = flip[j + 1] ? 1'b0 : hold_done_q[j];
			rel_t[j]  = flip[j + 1] ? 1'b1 : released_q[j];
			if (start_now[j]) begin
				press_start_d[j] = now;
			end
			el_disc[j] = start_now[j] ? (discovery_q == '0)
				: elapsed(now, press_start_q[j], discovery_q);
			el_conf[j] = start_now[j] ? (confirm_q == '0)
				: elapsed(now, press_start_q[j], confirm_q);
		end

		// release needed when arming began with a pairing button down
		raw_pair  = lv[BTN_PAIR] || lv[BTN_BOOT] || lv[BTN_EXPR];
		stab_pair = |stable_d[BTN_EXPR:BTN_PAIR];
		armed     = st == ST_ARMED;
		if (armed && !prev_armed_q) begin
			rel_req_d = raw_pair || stab_pair;
		end else if (!armed && prev_armed_q) begin
			rel_req_d = 1'b0;
		end
		if (!raw_pair && !stab_pair) begin
			rel_req_d = 1'b0;
		end

		for (int j = 0; j < NUM_PAIR; j++) begin
			fire[j] = stable_d[j + 1] && !hold_t[j] && rel_t[j] &&
				((st == ST_IDLE && el_disc[j]) ||
				(st == ST_ARMED && !rel_req_d && el_conf[j]));
		end
		any_fire = |fire;
		for (int j = 0; j < NUM_PAIR; j++) begin
			if (any_fire && stable_d[j + 1]) begin
				hold_done_d[j] = 1'b1;
				released_d[j]  = 1'b0;
			end else begin
				hold_done_d[j] = hold_t[j];
				released_d[j]  = rel_t[j];
			end
		end

		// candidate pushes in queue order
		push_v[0] = pressed[BTN_VOICE] && (st == ST_IDLE || st == ST_RECORDING);
		push_a[0] = (st == ST_IDLE) ? ACT_VOICE_START : ACT_VOICE_STOP;
		push_v[1] = any_fire;
		push_a[1] = (st == ST_IDLE) ? ACT_DISCOVERY : ACT_CONFIRM;
		push_v[2] = pressed[BTN_EXPR] && st == ST_IDLE;
		push_a[2] = ACT_EXPRESSION;
		push_v[3] = pressed[BTN_TOUCH] && st == ST_IDLE;
		push_a[3] = ACT_TOUCH;
		push_v[4] = pressed[BTN_VUP] ^ pressed[BTN_VDN];
		push_a[4] = pressed[BTN_VUP] ? ACT_VOL_UP : ACT_VOL_DOWN;
		push_v[5] = pressed[BTN_NEXT] ^ pressed[BTN_PREV];
		push_a[5] = pressed[BTN_NEXT] ? ACT_NEXT : ACT_PREV;

		// slot of each push behind the current tail
		total = PW'(count_q);
		for (int j = 0; j < NPUSH; j++) begin
			pos[j] = total;
			total  = total + PW'(push_v[j]);
		end

		if (s1_data_s1.command == CMD_POP) begin
			// pop: restore button state, shift the queue down one entry
			raw_d         = raw_q;
			stable_d      = stable_q;
			change_time_d = change_time_q;
			press_start_d = press_start_q;
			hold_done_d   = hold_done_q;
			released_d    = released_q;
			rel_req_d     = rel_req_q;
			if (count_q != '0) begin
				result.action = fifo_q[0];
				for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
					fifo_d[k] = fifo_q[k + 1];
				end
				count_d = CW'(count_q - 1'b1);
			end
		end else begin
			// tick: drop pushes that fall past the last entry
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				for (int j = 0; j < NPUSH; j++) begin
					if (push_v[j] && pos[j] == PW'(k)) begin
						fifo_d[k] = push_a[j];
					end
				end
			end
			count_d = (total > PW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(total);
			prev_armed_d = armed;
		end

		cnt_ext = 8'(count_d);
		result.pending_count = cnt_ext[3:0];
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q         <= '0;
			stable_q      <= '0;
			change_time_q <= '0;
			press_start_q <= '0;
			hold_done_q   <= '0;
			released_q    <= '0;
			prev_armed_q  <= 1'b0;
			rel_req_q     <= 1'b0;
			count_q       <= '0;
		end else if (commit) begin
			raw_q         <= raw_d;
			stable_q      <= stable_d;
			change_time_q <= change_time_d;
			press_start_q <= press_start_d;
			hold_done_q   <= hold_done_d;
			released_q    <= released_d;
			prev_armed_q  <= prev_armed_d;
			rel_req_q     <= rel_req_d;
			count_q       <= count_d;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (commit) begin
			for (int k = 0; k < QUEUE_DEPTH; k++) begin
				fifo_q[k] <= fifo_d[k];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= result;
		end
	end

`ifndef SYNTHESIS
	// queue count stays within the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// a pop on an empty queue reports no action
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		commit && s1_data_s1.command == CMD_POP && count_q == '0
		|=> out_data_q.action == ACT_NONE)
		else $error("pop on empty queue returned an action");

	// a tick never shrinks the queue
	a_tick_grows: assert property (@(posedge clk) disable iff (!arst_n)
		commit && s1_data_s1.command == CMD_TICK |=> count_q >= $past(count_q))
		else $error("tick reduced queue count");

	// a fired hold and a set released flag never coexist for one button
	a_hold_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_done_q & released_q) == '0)
		else $error("hold done and released both set");

	// a result only enters the output register when it is free or draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_data_q))
		else $error("stalled result overwritten");
`endif

endmodule

FILE: tb/bdaq_result_check.sv
// Result checker for the button debounce action queue: mirrors the register
// writes, predicts every result from the accepted items and compares it.
// Depends on bdaq_pkg.
`timescale 1ns / 1ps

module bdaq_result_check #(
	parameter int DEPTH = bdaq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bdaq_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bdaq_pkg::REG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  bdaq_pkg::in_item_t             in_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  bdaq_pkg::out_item_t            out_data,
	output int                             fail_count,
	output int                             open_results
);
	import bdaq_pkg::*;

	// timing registers as last written
	logic [REG_W-1:0] debounce_us;
	logic [REG_W-1:0] discovery_us;
	logic [REG_W-1:0] confirm_us;

	// debouncer and hold tracking
	logic [NUM_BTN-1:0]  raw_lv;
	logic [NUM_BTN-1:0]  stable_lv;
	logic [TIME_W-1:0]   changed_at [NUM_BTN];
	logic [TIME_W-1:0]   hold_start [NUM_PAIR];
	logic [NUM_PAIR-1:0] hold_fired;
	logic [NUM_PAIR-1:0] released;
	logic                was_armed;
	logic                need_release;

	// queued actions and the results still to arrive
	action_t   action_q [$];
	out_item_t due_results [$];

	// a timestamp below the reference never counts as elapsed
	function automatic logic held_long_enough(logic [TIME_W-1:0] now,
			logic [TIME_W-1:0] since, logic [REG_W-1:0] thr);
		return now >= since && (now - since) >= TIME_W'(thr);
	endfunction

	function automatic logic [NUM_BTN-1:0] levels_of(in_item_t it);
		logic [NUM_BTN-1:0] lv;
		lv[BTN_VOICE] = it.voice_level;
		lv[BTN_PAIR]  = it.pair_level;
		lv[BTN_BOOT]  = it.boot_level;
		lv[BTN_EXPR]  = it.expression_level;
		lv[BTN_VUP]   = it.volume_up_level;
		lv[BTN_VDN]   = it.volume_down_level;
		lv[BTN_NEXT]  = it.next_track_level;
		lv[BTN_PREV]  = it.prev_track_level;
		lv[BTN_TOUCH] = it.touch_level;
		return lv;
	endfunction

	task automatic queue_action(action_t a);
		if (action_q.size() < DEPTH) action_q.push_back(a);
	endtask

	task automatic apply_tick(in_item_t it);
		logic [NUM_BTN-1:0] lv;
		logic [NUM_BTN-1:0] taken;
		logic [TIME_W-1:0]  now;
		logic               raw_pair;
		logic               stab_pair;
		logic               armed;
		logic               fired;
		sys_state_t         st;
		now   = it.sample_time_us;
		st    = it.system_state;
		lv    = levels_of(it);
		taken = '0;

		// debounce every button
		for (int i = 0; i < NUM_BTN; i++) begin
			if (lv[i] != raw_lv[i]) begin
				raw_lv[i]     = lv[i];
				changed_at[i] = now;
			end
			if (stable_lv[i] != raw_lv[i] && held_long_enough(now, changed_at[i], debounce_us)) begin
				stable_lv[i] = raw_lv[i];
				if (i >= BTN_PAIR && i <= BTN_EXPR) begin
					if (raw_lv[i]) hold_start[i - BTN_PAIR] = now;
					hold_fired[i - BTN_PAIR] = 1'b0;
					released[i - BTN_PAIR]   = 1'b1;
				end
				if (raw_lv[i]) taken[i] = 1'b1;
			end
		end

		// release needed when arming starts with a pairing button down
		raw_pair  = |lv[BTN_EXPR:BTN_PAIR];
		stab_pair = |stable_lv[BTN_EXPR:BTN_PAIR];
		armed     = (st == ST_ARMED);
		if (armed && !was_armed) need_release = raw_pair || stab_pair;
		else if (!armed && was_armed) need_release = 1'b0;
		if (!raw_pair && !stab_pair) need_release = 1'b0;

		if (taken[BTN_VOICE]) begin
			if (st == ST_IDLE) queue_action(ACT_VOICE_START);
			else if (st == ST_RECORDING) queue_action(ACT_VOICE_STOP);
		end

		// first pairing button whose hold is long enough fires for all held ones
		fired = 1'b0;
		for (int i = 0; i < NUM_PAIR; i++) begin
			if (!fired && stable_lv[BTN_PAIR + i] && !hold_fired[i] && released[i]) begin
				if (st == ST_IDLE && held_long_enough(now, hold_start[i], discovery_us)) begin
					fired = 1'b1;
					queue_action(ACT_DISCOVERY);
				end else if (st == ST_ARMED && !need_release &&
						held_long_enough(now, hold_start[i], confirm_us)) begin
					fired = 1'b1;
					queue_action(ACT_CONFIRM);
				end
				if (fired) begin
					for (int j = 0; j < NUM_PAIR; j++) begin
						if (stable_lv[BTN_PAIR + j]) begin
							hold_fired[j] = 1'b1;
							released[j]   = 1'b0;
						end
					end
				end
			end
		end

		if (taken[BTN_EXPR] && st == ST_IDLE) queue_action(ACT_EXPRESSION);
		if (taken[BTN_TOUCH] && st == ST_IDLE) queue_action(ACT_TOUCH);

		// opposite presses in one tick cancel
		if (taken[BTN_VUP] && !taken[BTN_VDN]) queue_action(ACT_VOL_UP);
		else if (taken[BTN_VDN] && !taken[BTN_VUP]) queue_action(ACT_VOL_DOWN);
		if (taken[BTN_NEXT] && !taken[BTN_PREV]) queue_action(ACT_NEXT);
		else if (taken[BTN_PREV] && !taken[BTN_NEXT]) queue_action(ACT_PREV);

		was_armed = armed;
	endtask

	task automatic run_item(in_item_t it, output out_item_t res);
		res.action = ACT_NONE;
		if (it.command == CMD_POP) begin
			if (action_q.size() != 0) res.action = action_q.pop_front();
		end else begin
			apply_tick(it);
		end
		res.pending_count = 4'(action_q.size());
	endtask

	// register writes, result compare, then prediction of the new transfer
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			debounce_us  = DEBOUNCE_RST;
			discovery_us = DISCOVERY_RST;
			confirm_us   = CONFIRM_RST;
			raw_lv       = '0;
			stable_lv    = '0;
			foreach (changed_at[i]) changed_at[i] = '0;
			foreach (hold_start[i]) hold_start[i] = '0;
			hold_fired   = '0;
			released     = '0;
			was_armed    = 1'b0;
			need_release = 1'b0;
			action_q.delete();
			due_results.delete();
			fail_count   = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DEBOUNCE:  debounce_us  = cfg_data;
					REG_DISCOVERY: discovery_us = cfg_data;
					REG_CONFIRM:   confirm_us   = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("unexpected result: action %0d, pending_count %0d",
						out_data.action, out_data.pending_count);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					if (out_data.action !== want.action) begin
						$error("action: expected %0d, actual %0d", want.action, out_data.action);
						fail_count++;
					end
					if (out_data.pending_count !== want.pending_count) begin
						$error("pending_count: expected %0d, actual %0d",
							want.pending_count, out_data.pending_count);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				run_item(in_data, want);
				due_results.push_back(want);
			end
		end
		open_results = due_results.size();
	end

endmodule

FILE: tb/tb_button_debounce_action_queue.sv
// Testbench top for the button debounce action queue: clock, reset, register
// writes, directed and random item streams, receiver stalls and the verdict.
// Depends on bdaq_pkg, button_debounce_action_queue and bdaq_result_check.
`timescale 1ns / 1ps

module tb_button_debounce_action_queue;
	import bdaq_pkg::*;

	localparam int PHASE_ITEMS   = 330;
	localparam int SETTLE_CYCLES = 6;
	localparam int IDLE_LIMIT    = 2000;
	// index past the register list, written to check that it is ignored
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_data;
	int                 fail_count;
	int                 open_results;

	int                 burst_left;
	int                 idle_cycles = 0;
	int                 stall_left = 0;
	stall_mode_t        stall_mode = STALL_NONE;
	logic [TIME_W-1:0]  now_us;
	logic [NUM_BTN-1:0] held;
	sys_state_t         held_state;

	button_debounce_action_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	bdaq_result_check #(
		.DEPTH(QUEUE_DEPTH_DEF)
	) u_result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.fail_count   (fail_count),
		.open_results (open_results)
	);

	always #1 clk = ~clk;

	// receiver stall pattern, re-chosen whenever its countdown runs out
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(20, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
			default:     out_stall <= ((stall_left % 8) < 5);
		endcase
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_button_debounce_action_queue failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic in_item_t tick_item(logic [NUM_BTN-1:0] lv, logic [TIME_W-1:0] t,
			sys_state_t st);
		in_item_t it;
		it.command           = CMD_TICK;
		it.voice_level       = lv[BTN_VOICE];
		it.pair_level        = lv[BTN_PAIR];
		it.boot_level        = lv[BTN_BOOT];
		it.expression_level  = lv[BTN_EXPR];
		it.volume_up_level   = lv[BTN_VUP];
		it.volume_down_level = lv[BTN_VDN];
		it.next_track_level  = lv[BTN_NEXT];
		it.prev_track_level  = lv[BTN_PREV];
		it.touch_level       = lv[BTN_TOUCH];
		it.sample_time_us    = t;
		it.system_state      = st;
		return it;
	endfunction

	function automatic logic [TIME_W-1:0] any_time();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TIME_W-1:0];
	endfunction

	// pop with every other field random
	function automatic in_item_t pop_item();
		in_item_t    it;
		logic [95:0] w;
		w  = {$urandom, $urandom, $urandom};
		it = w[$bits(in_item_t)-1:0];
		it.command = CMD_POP;
		return it;
	endfunction

	function automatic sys_state_t pick_state();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return ST_IDLE;
		if (r < 6) return ST_RECORDING;
		if (r < 9) return ST_ARMED;
		return ST_OTHER;
	endfunction

	// one transfer, sent in bursts with random gaps
	task automatic send(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				gap        = 0;
				burst_left = $urandom_range(40, 150);
			end else begin
				gap        = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 24);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	// hold off until every result is back and the pipeline is empty
	task automatic drain();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (open_results != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic set_timing(input logic [REG_W-1:0] deb, input logic [REG_W-1:0] disc,
			input logic [REG_W-1:0] conf);
		cfg_write(REG_DEBOUNCE, deb);
		cfg_write(REG_DISCOVERY, disc);
		cfg_write(REG_CONFIRM, conf);
		cfg_write(REG_UNUSED, $urandom);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// presses, holds, arming, opposite presses, backwards time, full queue
	task automatic run_directed();
		logic [NUM_BTN-1:0] pair_only;
		logic [NUM_BTN-1:0] vup_only;
		logic [NUM_BTN-1:0] mix;
		logic [NUM_BTN-1:0] prev_only;
		pair_only = '0;
		pair_only[BTN_PAIR] = 1'b1;
		vup_only = '0;
		vup_only[BTN_VUP] = 1'b1;
		mix = '0;
		mix[BTN_VOICE] = 1'b1;
		mix[BTN_VDN]   = 1'b1;
		mix[BTN_NEXT]  = 1'b1;
		prev_only = '0;
		prev_only[BTN_PREV] = 1'b1;

		// pop on empty queue
		send(pop_item());
		// everything pressed, taken, then held into discovery
		send(tick_item('0, 63'd0, ST_IDLE));
		send(tick_item('1, 63'd100, ST_IDLE));
		send(tick_item('1, 63'd40000, ST_IDLE));
		send(tick_item('1, 63'd3040000, ST_IDLE));
		// arming with buttons down, then release and a confirm hold
		send(tick_item('1, 63'd3040001, ST_ARMED));
		send(tick_item('0, 63'd3040002, ST_ARMED));
		send(tick_item('0, 63'd3100000, ST_ARMED));
		send(tick_item(pair_only, 63'd3100001, ST_ARMED));
		send(tick_item(pair_only, 63'd3200000, ST_ARMED));
		send(tick_item(pair_only, 63'd4700000, ST_ARMED));
		// time going backwards
		send(tick_item(vup_only, 63'd5, ST_RECORDING));
		send(tick_item(vup_only, 63'd4, ST_RECORDING));
		send(tick_item(vup_only, 63'd40000, ST_RECORDING));
		// voice stop plus more actions than the queue holds
		send(tick_item(mix, 63'd40001, ST_RECORDING));
		send(tick_item(mix, 63'd80000, ST_RECORDING));
		send(tick_item(prev_only, '1, ST_OTHER));
		repeat (8) send(pop_item());
	endtask

	// mostly steady presses over a rising clock, some pops, some noise
	task automatic random_phase(input int n, input int unsigned step_max, input bit huge);
		int                 sel;
		logic [NUM_BTN-1:0] lv;
		logic [NUM_BTN-1:0] mask;
		logic [TIME_W-1:0]  t;
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				send(pop_item());
			end else if (sel < 33) begin
				if ($urandom_range(0, 1)) t = any_time();
				else t = now_us - TIME_W'($urandom_range(0, 1000));
				send(tick_item(NUM_BTN'($urandom), t, sys_state_t'($urandom_range(0, 3))));
			end else begin
				if (huge) now_us = now_us + TIME_W'({$urandom_range(0, 3), $urandom});
				else now_us = now_us + TIME_W'($urandom_range(0, step_max));
				if ($urandom_range(0, 3) == 0) begin
					mask = '0;
					case ($urandom_range(0, 5))
						0: begin
							mask[BTN_VUP] = 1'b1;
							mask[BTN_VDN] = 1'b1;
						end
						1: begin
							mask[BTN_NEXT] = 1'b1;
							mask[BTN_PREV] = 1'b1;
						end
						default: mask[$urandom_range(0, NUM_BTN - 1)] = 1'b1;
					endcase
					held = held ^ mask;
				end
				if ($urandom_range(0, 19) == 0) held_state = pick_state();
				// short bounce on one button
				lv = held;
				if ($urandom_range(0, 9) == 0) lv[$urandom_range(0, NUM_BTN - 1)] ^= 1'b1;
				send(tick_item(lv, now_us, held_state));
			end
			if ($urandom_range(0, 199) == 0) drain();
		end
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_DEBOUNCE;
		cfg_data    = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		burst_left  = 0;
		now_us      = '0;
		held        = '0;
		held_state  = ST_IDLE;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		drain();

		set_timing(32'd20, 32'd300, 32'd150);
		random_phase(PHASE_ITEMS, 40, 1'b0);
		drain();
		set_timing('0, '0, '0);
		random_phase(PHASE_ITEMS, 3, 1'b0);
		drain();
		set_timing('1, '1, '1);
		random_phase(PHASE_ITEMS, 0, 1'b1);
		drain();
		set_timing($urandom_range(0, 100), $urandom_range(0, 1000), $urandom_range(0, 500));
		random_phase(PHASE_ITEMS, 60, 1'b0);
		drain();
		set_timing(32'd5, 32'd40, 32'd25);
		random_phase(PHASE_ITEMS, 10, 1'b0);
		drain();

		if (fail_count == 0) begin
			$display("tb_button_debounce_action_queue passed");
		end else begin
			$display("tb_button_debounce_action_queue failed");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/bdaq_pkg.sv
hdl/button_debounce_action_queue.sv
tb/bdaq_result_check.sv
tb/tb_button_debounce_action_queue.sv
